FILE: design/spwm_pkg.sv
package spwm_pkg;

   localparam int POS_WIDTH    = 12;
   localparam int DUTY_WIDTH   = 16;
   localparam int STEP_WIDTH   = 15;
   localparam int MAG_WIDTH    = 15;
   localparam int PROD_WIDTH   = 31;
   localparam int QUO_WIDTH    = 17;
   localparam int RECIP_WIDTH  = 32;
   localparam int PHASE_WIDTH  = 17;
   localparam int CSR_IDX_WIDTH  = 3;
   localparam int CSR_DATA_WIDTH = 16;
   localparam int REQ_DATA_WIDTH = 16;
   localparam int RSP_DATA_WIDTH = 72;

   localparam int SINE_AMPLITUDE = 32000;
   localparam int DUTY_DIVISOR   = 32000;
   localparam logic [POS_WIDTH-1:0] PHASE_OFFSET = 12'd1365;
   localparam logic [63:0] PI_Q30 = 64'd3373259426;

   localparam int DIV_SHIFT = PROD_WIDTH + 15;
   localparam logic [RECIP_WIDTH-1:0] DIV_RECIP = RECIP_WIDTH'(
      ((64'd1 << DIV_SHIFT) + 64'(DUTY_DIVISOR) - 64'd1) / 64'(DUTY_DIVISOR));
   localparam logic [QUO_WIDTH-1:0] PHASE_LIMIT = 17'd32767;

   localparam logic [CSR_IDX_WIDTH-1:0] CSR_RAMP_ENABLE   = 3'd0;
   localparam logic [CSR_IDX_WIDTH-1:0] CSR_TARGET_DUTY   = 3'd1;
   localparam logic [CSR_IDX_WIDTH-1:0] CSR_RAMP_INTERVAL = 3'd2;
   localparam logic [CSR_IDX_WIDTH-1:0] CSR_RAMP_STEP     = 3'd3;
   localparam logic [CSR_IDX_WIDTH-1:0] CSR_DUTY_MAX      = 3'd4;
   localparam logic [CSR_IDX_WIDTH-1:0] CSR_DUTY_MIN      = 3'd5;
   localparam logic [CSR_IDX_WIDTH-1:0] CSR_ZERO_OFFSET   = 3'd6;

   localparam logic                          RST_RAMP_ENABLE   = 1'b1;
   localparam logic signed [DUTY_WIDTH-1:0]  RST_TARGET_DUTY   = 16'sd100;
   localparam logic [DUTY_WIDTH-1:0]         RST_RAMP_INTERVAL = 16'd3;
   localparam logic [STEP_WIDTH-1:0]         RST_RAMP_STEP     = 15'd1;
   localparam logic signed [DUTY_WIDTH-1:0]  RST_DUTY_MAX      = 16'sd300;
   localparam logic signed [DUTY_WIDTH-1:0]  RST_DUTY_MIN      = -16'sd300;
   localparam logic [POS_WIDTH-1:0]          RST_ZERO_OFFSET   = 12'd0;

endpackage

FILE: design/spwm_three_phase_duty_unit.sv
// Three-phase sine PWM duty generator.
// The req channel takes one rotor position word per tick in req_tdata. In ramp
// mode only every ramp_interval-th tick updates the ramped duty and yields a
// rsp word; the other ticks are absorbed and give no word. With ramp mode off
// every tick yields a word that uses target_duty directly.
// Each rsp word carries the applied duty, the U, V and W phase duties and the
// high-side select of each phase.
// An accepted word passes through five registered stages (input, sine ROM
// read, amplitude multiply, reciprocal multiply, output) to rsp_tvalid, so one
// word per cycle is sustained while rsp_tready stays high.
// A stall on rsp_tready holds the output register; earlier stages keep
// filling their empty slots, so req_tready drops only once every stage holds
// a word.
// The csr channel writes one register per cycle and is always ready; the user
// must write it only while the pipeline is empty, which the block does not enforce.
// Reset clears the pipeline, the tick counter and the ramped duty, and loads
// the register reset values. The sine ROM is a constant table and needs no
// initialization pass.
module spwm_three_phase_duty_unit #(
   parameter int SINE_ENTRIES = 1024
) (
   input  logic clock,
   input  logic reset,
   input  logic req_tvalid,
   output logic req_tready,
   // [11:0] rotor_position, [15:12] zero
   input  logic [spwm_pkg::REQ_DATA_WIDTH-1:0] req_tdata,
   output logic rsp_tvalid,
   input  logic rsp_tready,
   // [15:0] applied_duty, [31:16] duty_u, [47:32] duty_v, [64:48] duty_w,
   // [65] high_side_u, [66] high_side_v, [67] high_side_w, [71:68] zero
   output logic [spwm_pkg::RSP_DATA_WIDTH-1:0] rsp_tdata,
   input  logic csr_valid,
   output logic csr_ready,
   input  logic [spwm_pkg::CSR_IDX_WIDTH-1:0] csr_index,
   input  logic [spwm_pkg::CSR_DATA_WIDTH-1:0] csr_data
);

   localparam int IDX_WIDTH   = $clog2(SINE_ENTRIES);
   localparam int SCALE_WIDTH = 11 + IDX_WIDTH;
   localparam int MAG_W       = spwm_pkg::MAG_WIDTH;
   localparam int DW          = spwm_pkg::DUTY_WIDTH;
   localparam int PW          = spwm_pkg::POS_WIDTH;
   localparam logic [63:0] ANGLE_DIVISOR = 64'(2 * SINE_ENTRIES);

   typedef logic [MAG_W-1:0] rom_type [SINE_ENTRIES];

   function automatic logic [MAG_W-1:0] sine_entry(input int unsigned i);
      logic [63:0] x;
      logic [63:0] x2;
      logic [63:0] term;
      logic [63:0] sum;
      logic [63:0] v;
      begin
         x = (64'(i) * spwm_pkg::PI_Q30) / ANGLE_DIVISOR;
         x2 = (x * x) >> 30;
         term = x;
         sum = x;
         term = ((term * x2) >> 30) / 64'd6;   sum = sum - term;
         term = ((term * x2) >> 30) / 64'd20;  sum = sum + term;
         term = ((term * x2) >> 30) / 64'd42;  sum = sum - term;
         term = ((term * x2) >> 30) / 64'd72;  sum = sum + term;
         term = ((term * x2) >> 30) / 64'd110; sum = sum - term;
         term = ((term * x2) >> 30) / 64'd156; sum = sum + term;
         term = ((term * x2) >> 30) / 64'd210; sum = sum - term;
         term = ((term * x2) >> 30) / 64'd272; sum = sum + term;
         term = ((term * x2) >> 30) / 64'd342; sum = sum - term;
         term = ((term * x2) >> 30) / 64'd420; sum = sum + term;
         v = (sum * 64'(spwm_pkg::SINE_AMPLITUDE) + (64'd1 << 29)) >> 30;
         if (v > 64'(spwm_pkg::SINE_AMPLITUDE)) begin
            v = 64'(spwm_pkg::SINE_AMPLITUDE);
         end
         return MAG_W'(v);
      end
   endfunction

   function automatic rom_type build_rom();
      rom_type r;
      begin
         for (int i = 0; i < SINE_ENTRIES; i++) begin
            r[i] = sine_entry(i);
         end
         return r;
      end
   endfunction

   localparam rom_type SINE_ROM = build_rom();

   // Configuration registers.
   logic                  ramp_enable_ff;
   logic signed [DW-1:0]  target_duty_ff;
   logic [DW-1:0]         ramp_interval_ff;
   logic [spwm_pkg::STEP_WIDTH-1:0] ramp_step_ff;
   logic signed [DW-1:0]  duty_max_ff;
   logic signed [DW-1:0]  duty_min_ff;
   logic [PW-1:0]         zero_offset_ff;

   // Ramp state.
   logic [DW-1:0]         tick_count_ff, tick_count_in;
   logic signed [DW-1:0]  ramped_duty_ff, ramped_duty_in;

   // Stage valids.
   logic s1_valid_ff, s2_valid_ff, s3_valid_ff, s4_valid_ff, rsp_valid_ff;
   logic s1_valid_in;
   logic s1_adv, s2_adv, s3_adv, s4_adv, out_adv;
   logic req_accept;
   logic tick_skip;

   // Stage 1: duty magnitude, ROM addresses, signs, sides.
   logic signed [DW-1:0]  s1_duty_ff, s1_duty_in;
   logic [DW-1:0]         s1_dmag_ff, s1_dmag_in;
   logic                  s1_neg_u_ff, s1_neg_u_in, s1_neg_v_ff, s1_neg_v_in;
   logic [IDX_WIDTH-1:0]  s1_idx_u_ff, s1_idx_u_in, s1_idx_v_ff, s1_idx_v_in;
   logic [2:0]            s1_side_ff, s1_side_in;

   // Stage 2: sine magnitudes.
   logic signed [DW-1:0]  s2_duty_ff;
   logic [DW-1:0]         s2_dmag_ff;
   logic                  s2_neg_u_ff, s2_neg_v_ff;
   logic [MAG_W-1:0]      s2_mag_u_ff, s2_mag_v_ff;
   logic [2:0]            s2_side_ff;

   // Stage 3: amplitude products.
   logic signed [DW-1:0]  s3_duty_ff;
   logic                  s3_neg_u_ff, s3_neg_v_ff;
   logic [spwm_pkg::PROD_WIDTH-1:0] s3_prod_u_ff, s3_prod_u_in;
   logic [spwm_pkg::PROD_WIDTH-1:0] s3_prod_v_ff, s3_prod_v_in;
   logic [2:0]            s3_side_ff;

   // Stage 4: quotients.
   logic signed [DW-1:0]  s4_duty_ff;
   logic                  s4_neg_u_ff, s4_neg_v_ff;
   logic [spwm_pkg::QUO_WIDTH-1:0] s4_quo_u_ff, s4_quo_u_in;
   logic [spwm_pkg::QUO_WIDTH-1:0] s4_quo_v_ff, s4_quo_v_in;
   logic [2:0]            s4_side_ff;
   logic [spwm_pkg::PROD_WIDTH+spwm_pkg::RECIP_WIDTH-1:0] full_u, full_v;

   // Output register.
   logic signed [DW-1:0]  rsp_duty_ff;
   logic signed [DW-1:0]  rsp_u_ff, rsp_u_in, rsp_v_ff, rsp_v_in;
   logic signed [spwm_pkg::PHASE_WIDTH-1:0] rsp_w_ff, rsp_w_in;
   logic [2:0]            rsp_side_ff;

   // Ramp arithmetic.
   logic [DW-1:0]         tick_next;
   logic signed [DW:0]    ramp_down, ramp_up, tgt_wide;
   logic signed [DW-1:0]  ramp_moved;
   logic signed [DW-1:0]  duty_sel;

   // Angles.
   logic [PW-1:0]         angle_u, angle_v, angle_w;
   logic [9:0]            quarter_u, quarter_v;
   logic [SCALE_WIDTH-1:0] scaled_u, scaled_v;
   logic [spwm_pkg::QUO_WIDTH-1:0] sat_u, sat_v;

   assign csr_ready = 1'b1;

   assign out_adv    = !rsp_valid_ff || rsp_tready;
   assign s4_adv     = !s4_valid_ff || out_adv;
   assign s3_adv     = !s3_valid_ff || s4_adv;
   assign s2_adv     = !s2_valid_ff || s3_adv;
   assign s1_adv     = !s1_valid_ff || s2_adv;
   assign req_tready = s1_adv;
   assign req_accept = req_tvalid && req_tready;

   always_comb begin
      tick_next = tick_count_ff + 1'b1;
      tick_skip = ramp_enable_ff && (tick_next < ramp_interval_ff);
      tgt_wide  = (DW+1)'(target_duty_ff);
      ramp_down = (DW+1)'(ramped_duty_ff) - (DW+1)'(signed'({1'b0, ramp_step_ff}));
      ramp_up   = (DW+1)'(ramped_duty_ff) + (DW+1)'(signed'({1'b0, ramp_step_ff}));
      priority if (ramped_duty_ff > target_duty_ff) begin
         ramp_moved = (ramp_down < tgt_wide) ? target_duty_ff : DW'(ramp_down);
      end else if (ramped_duty_ff < target_duty_ff) begin
         ramp_moved = (ramp_up > tgt_wide) ? target_duty_ff : DW'(ramp_up);
      end else begin
         ramp_moved = ramped_duty_ff;
      end
      priority if (ramp_moved > duty_max_ff) begin
         ramped_duty_in = duty_max_ff;
      end else if (ramp_moved < duty_min_ff) begin
         ramped_duty_in = duty_min_ff;
      end else begin
         ramped_duty_in = ramp_moved;
      end
      tick_count_in = tick_skip ? tick_next : '0;
      duty_sel = ramp_enable_ff ? ramped_duty_in : target_duty_ff;
      s1_valid_in = req_accept && !tick_skip;
   end

   always_comb begin
      angle_u = req_tdata[PW-1:0] - zero_offset_ff;
      angle_v = angle_u + spwm_pkg::PHASE_OFFSET;
      angle_w = angle_v + spwm_pkg::PHASE_OFFSET;
      quarter_u = angle_u[10] ? ~angle_u[9:0] : angle_u[9:0];
      quarter_v = angle_v[10] ? ~angle_v[9:0] : angle_v[9:0];
      scaled_u = SCALE_WIDTH'(quarter_u) * SCALE_WIDTH'(SINE_ENTRIES);
      scaled_v = SCALE_WIDTH'(quarter_v) * SCALE_WIDTH'(SINE_ENTRIES);
      s1_idx_u_in = scaled_u[10 +: IDX_WIDTH];
      s1_idx_v_in = scaled_v[10 +: IDX_WIDTH];
      s1_neg_u_in = angle_u[11];
      s1_neg_v_in = angle_v[11];
      s1_side_in  = {!angle_w[11], !angle_v[11], !angle_u[11]};
      s1_duty_in  = duty_sel;
      s1_dmag_in  = duty_sel[DW-1] ? DW'(-duty_sel) : DW'(duty_sel);
   end

   always_comb begin
      s3_prod_u_in = spwm_pkg::PROD_WIDTH'(s2_mag_u_ff) * spwm_pkg::PROD_WIDTH'(s2_dmag_ff);
      s3_prod_v_in = spwm_pkg::PROD_WIDTH'(s2_mag_v_ff) * spwm_pkg::PROD_WIDTH'(s2_dmag_ff);
      full_u = (spwm_pkg::PROD_WIDTH+spwm_pkg::RECIP_WIDTH)'(s3_prod_u_ff)
             * (spwm_pkg::PROD_WIDTH+spwm_pkg::RECIP_WIDTH)'(spwm_pkg::DIV_RECIP);
      full_v = (spwm_pkg::PROD_WIDTH+spwm_pkg::RECIP_WIDTH)'(s3_prod_v_ff)
             * (spwm_pkg::PROD_WIDTH+spwm_pkg::RECIP_WIDTH)'(spwm_pkg::DIV_RECIP);
      s4_quo_u_in = full_u[spwm_pkg::DIV_SHIFT +: spwm_pkg::QUO_WIDTH];
      s4_quo_v_in = full_v[spwm_pkg::DIV_SHIFT +: spwm_pkg::QUO_WIDTH];
   end

   always_comb begin
      sat_u = (s4_quo_u_ff > spwm_pkg::PHASE_LIMIT) ? spwm_pkg::PHASE_LIMIT : s4_quo_u_ff;
      sat_v = (s4_quo_v_ff > spwm_pkg::PHASE_LIMIT) ? spwm_pkg::PHASE_LIMIT : s4_quo_v_ff;
      rsp_u_in = (s4_neg_u_ff ^ s4_duty_ff[DW-1]) ? -DW'(sat_u) : DW'(sat_u);
      rsp_v_in = (s4_neg_v_ff ^ s4_duty_ff[DW-1]) ? -DW'(sat_v) : DW'(sat_v);
      rsp_w_in = -((spwm_pkg::PHASE_WIDTH)'(rsp_u_in) + (spwm_pkg::PHASE_WIDTH)'(rsp_v_in));
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ramp_enable_ff   <= spwm_pkg::RST_RAMP_ENABLE;
         target_duty_ff   <= spwm_pkg::RST_TARGET_DUTY;
         ramp_interval_ff <= spwm_pkg::RST_RAMP_INTERVAL;
         ramp_step_ff     <= spwm_pkg::RST_RAMP_STEP;
         duty_max_ff      <= spwm_pkg::RST_DUTY_MAX;
         duty_min_ff      <= spwm_pkg::RST_DUTY_MIN;
         zero_offset_ff   <= spwm_pkg::RST_ZERO_OFFSET;
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index)
            spwm_pkg::CSR_RAMP_ENABLE:   ramp_enable_ff   <= csr_data[0];
            spwm_pkg::CSR_TARGET_DUTY:   target_duty_ff   <= csr_data;
            spwm_pkg::CSR_RAMP_INTERVAL: ramp_interval_ff <= csr_data;
            spwm_pkg::CSR_RAMP_STEP:     ramp_step_ff     <= csr_data[spwm_pkg::STEP_WIDTH-1:0];
            spwm_pkg::CSR_DUTY_MAX:      duty_max_ff      <= csr_data;
            spwm_pkg::CSR_DUTY_MIN:      duty_min_ff      <= csr_data;
            spwm_pkg::CSR_ZERO_OFFSET:   zero_offset_ff   <= csr_data[PW-1:0];
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         tick_count_ff  <= '0;
         ramped_duty_ff <= '0;
         s1_valid_ff    <= 1'b0;
         s2_valid_ff    <= 1'b0;
         s3_valid_ff    <= 1'b0;
         s4_valid_ff    <= 1'b0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         if (req_accept && ramp_enable_ff) begin
            tick_count_ff <= tick_count_in;
            if (!tick_skip) begin
               ramped_duty_ff <= ramped_duty_in;
            end
         end
         if (s1_adv) begin
            s1_valid_ff <= s1_valid_in;
         end
         if (s2_adv) begin
            s2_valid_ff <= s1_valid_ff;
         end
         if (s3_adv) begin
            s3_valid_ff <= s2_valid_ff;
         end
         if (s4_adv) begin
            s4_valid_ff <= s3_valid_ff;
         end
         if (out_adv) begin
            rsp_valid_ff <= s4_valid_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (s1_adv) begin
         s1_duty_ff  <= s1_duty_in;
         s1_dmag_ff  <= s1_dmag_in;
         s1_neg_u_ff <= s1_neg_u_in;
         s1_neg_v_ff <= s1_neg_v_in;
         s1_idx_u_ff <= s1_idx_u_in;
         s1_idx_v_ff <= s1_idx_v_in;
         s1_side_ff  <= s1_side_in;
      end
      if (s2_adv) begin
         s2_duty_ff  <= s1_duty_ff;
         s2_dmag_ff  <= s1_dmag_ff;
         s2_neg_u_ff <= s1_neg_u_ff;
         s2_neg_v_ff <= s1_neg_v_ff;
         s2_mag_u_ff <= SINE_ROM[s1_idx_u_ff];
         s2_mag_v_ff <= SINE_ROM[s1_idx_v_ff];
         s2_side_ff  <= s1_side_ff;
      end
      if (s3_adv) begin
         s3_duty_ff   <= s2_duty_ff;
         s3_neg_u_ff  <= s2_neg_u_ff;
         s3_neg_v_ff  <= s2_neg_v_ff;
         s3_prod_u_ff <= s3_prod_u_in;
         s3_prod_v_ff <= s3_prod_v_in;
         s3_side_ff   <= s2_side_ff;
      end
      if (s4_adv) begin
         s4_duty_ff  <= s3_duty_ff;
         s4_neg_u_ff <= s3_neg_u_ff;
         s4_neg_v_ff <= s3_neg_v_ff;
         s4_quo_u_ff <= s4_quo_u_in;
         s4_quo_v_ff <= s4_quo_v_in;
         s4_side_ff  <= s3_side_ff;
      end
      if (out_adv) begin
         rsp_duty_ff <= s4_duty_ff;
         rsp_u_ff    <= rsp_u_in;
         rsp_v_ff    <= rsp_v_in;
         rsp_w_ff    <= rsp_w_in;
         rsp_side_ff <= s4_side_ff;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {4'd0, rsp_side_ff, rsp_w_ff, rsp_v_ff, rsp_u_ff, rsp_duty_ff};

`ifndef ASSERT_OFF
   // A tick held back by the ramp interval must not enter the pipeline.
   assert property (@(posedge clock) disable iff (reset)
      (req_accept && tick_skip) |=> !s1_valid_ff)
      else $error("skipped tick produced a word");

   // With ramping off the kept duty is left untouched.
   assert property (@(posedge clock) disable iff (reset)
      (req_accept && !ramp_enable_ff) |=> $stable(ramped_duty_ff))
      else $error("ramped duty changed with ramp disabled");

   // An empty output register means every stage can move, so input is open.
   assert property (@(posedge clock) disable iff (reset)
      !rsp_valid_ff |-> req_tready)
      else $error("input blocked while output register empty");

   // Phase duties saturate symmetrically and never reach the most negative code.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (rsp_u_ff != 16'sh8000) && (rsp_v_ff != 16'sh8000))
      else $error("phase duty outside symmetric range");
`endif

endmodule
